// ----- hw/rtl/pid_controller_three_mode_macros.svh -----
// assertion macros for the three-mode pid controller
`ifndef PID_CONTROLLER_THREE_MODE_MACROS_SVH
`define PID_CONTROLLER_THREE_MODE_MACROS_SVH

// concurrent check on a clock, quiet while reset is low
`define PCM_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen at a clock edge
`define PCM_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    `PCM_ASSERT_CLK(lbl, clk, rst_n, !(expr), msg)

`endif

// ----- hw/rtl/pcm_pkg.sv -----
// shared types, constants and codes of the three-mode pid controller
package pcm_pkg;

    localparam int VALUE_FRAC_BITS = 8;
    localparam int GAIN_FRAC_BITS  = 16;
    localparam int SUM_WIDTH       = 40;

    localparam int DATA_W     = 24;
    localparam int ERR_W      = 25;
    localparam int ALPHA_W    = 17;
    localparam int ALPHA_FRAC = 16;
    localparam int IDX_W      = 3;
    localparam int MUL_A_W    = 25;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1 << ALPHA_FRAC);

    // mode codes, the unused code runs as positional
    localparam logic [1:0] MODE_POS   = 2'd0;
    localparam logic [1:0] MODE_INC   = 2'd1;
    localparam logic [1:0] MODE_YAW   = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // register indexes
    localparam logic [IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [IDX_W-1:0] REG_GAIN_P = 3'd1;
    localparam logic [IDX_W-1:0] REG_GAIN_I = 3'd2;
    localparam logic [IDX_W-1:0] REG_GAIN_D = 3'd3;
    localparam logic [IDX_W-1:0] REG_ALPHA  = 3'd4;
    localparam logic [IDX_W-1:0] REG_OUT_LO = 3'd5;
    localparam logic [IDX_W-1:0] REG_OUT_HI = 3'd6;

    typedef enum logic [1:0] {
        MSEL_FILT,
        MSEL_P,
        MSEL_I,
        MSEL_D
    } t_msel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILT,
        S_FILT_WAIT,
        S_ERR,
        S_DIV,
        S_DIV_WAIT,
        S_SUM,
        S_MUL_P,
        S_WAIT_P,
        S_MUL_I,
        S_WAIT_I,
        S_MUL_D,
        S_WAIT_D,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic  load;
        logic  mul_go;
        t_msel msel;
        logic  filt_store;
        logic  err_step;
        logic  div_go;
        logic  sum_step;
        logic  acc_add;
        logic  out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] mode;
        logic       gi_zero;
        logic       mul_done;
        logic       div_done;
        logic       out_free;
    } t_stat;

endpackage

// ----- hw/rtl/pcm_if.sv -----
// request channels of the three-mode pid controller

interface pcm_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [pcm_pkg::DATA_W-1:0]   target;
    logic signed [pcm_pkg::DATA_W-1:0]   measured;
    modport source (output valid, output target, output measured, input ready);
    modport sink   (input valid, input target, input measured, output ready);
endinterface

interface pcm_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [pcm_pkg::DATA_W-1:0]   drive;
    logic                                output_limited;
    modport source (output valid, output drive, output output_limited, input ready);
    modport sink   (input valid, input drive, input output_limited, output ready);
endinterface

interface pcm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [pcm_pkg::IDX_W-1:0]         index;
    logic [pcm_pkg::DATA_W-1:0]        data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/pcm_mul.sv -----
// bit-serial signed multiplier, one multiplier bit per cycle
module pcm_mul #(
    parameter int B_W = pcm_pkg::SUM_WIDTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [pcm_pkg::MUL_A_W-1:0]    i_a,
    input  logic signed [B_W-1:0]                 i_b,
    output logic                                  o_done,
    output logic signed [pcm_pkg::MUL_A_W+B_W-1:0] o_prod
);
    localparam int A_W = pcm_pkg::MUL_A_W;
    localparam int PW  = A_W + B_W;
    localparam int CNT_W = $clog2(A_W);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [A_W-1:0]       r_a;
    logic signed [PW-1:0] r_b;
    logic signed [PW-1:0] r_acc;
    logic                 last;

    assign last = (r_cnt == CNT_W'(A_W - 1));

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift and add, top bit of a carries negative weight
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= {{A_W{i_b[B_W-1]}}, i_b};
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_a[0]) begin
                r_acc <= last ? (r_acc - r_b) : (r_acc + r_b);
            end
            r_b <= r_b <<< 1;
            r_a <= r_a >> 1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

// ----- hw/rtl/pcm_div.sv -----
// restoring unsigned divider, one quotient bit per cycle
module pcm_div #(
    parameter int N_W = pcm_pkg::DATA_W + pcm_pkg::GAIN_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [N_W-1:0]                i_num,
    input  logic [pcm_pkg::DATA_W-1:0]    i_den,
    output logic                          o_done,
    output logic [N_W-1:0]                o_quo
);
    localparam int D_W   = pcm_pkg::DATA_W;
    localparam int CNT_W = $clog2(N_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [D_W-1:0]   r_den;
    logic [D_W-1:0]   r_rem;
    logic [N_W-1:0]   r_q;
    logic [D_W:0]     trial;
    logic [D_W:0]     diff;
    logic             fits;

    assign trial = {r_rem, r_q[N_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign fits  = (trial >= {1'b0, r_den});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= i_num;
        end else if (r_busy) begin
            r_rem <= fits ? diff[D_W-1:0] : trial[D_W-1:0];
            r_q   <= {r_q[N_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
endmodule

// ----- hw/rtl/pcm_ctrl.sv -----
// sequencing state machine of the three-mode pid controller
module pcm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  pcm_pkg::t_stat  i_stat,
    output pcm_pkg::t_cmd   o_cmd
);
    pcm_pkg::t_state r_state;
    pcm_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pcm_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_stat.mode == pcm_pkg::MODE_YAW) ? pcm_pkg::S_ERR
                                                                 : pcm_pkg::S_FILT;
                end
            end
            pcm_pkg::S_FILT:      n_state = pcm_pkg::S_FILT_WAIT;
            pcm_pkg::S_FILT_WAIT: begin
                if (i_stat.mul_done) n_state = pcm_pkg::S_ERR;
            end
            pcm_pkg::S_ERR: begin
                if (i_stat.mode == pcm_pkg::MODE_INC) n_state = pcm_pkg::S_MUL_P;
                else if (i_stat.gi_zero)              n_state = pcm_pkg::S_SUM;
                else                                  n_state = pcm_pkg::S_DIV;
            end
            pcm_pkg::S_DIV:      n_state = pcm_pkg::S_DIV_WAIT;
            pcm_pkg::S_DIV_WAIT: begin
                if (i_stat.div_done) n_state = pcm_pkg::S_SUM;
            end
            pcm_pkg::S_SUM:    n_state = pcm_pkg::S_MUL_P;
            pcm_pkg::S_MUL_P:  n_state = pcm_pkg::S_WAIT_P;
            pcm_pkg::S_WAIT_P: begin
                if (i_stat.mul_done) n_state = pcm_pkg::S_MUL_I;
            end
            pcm_pkg::S_MUL_I:  n_state = pcm_pkg::S_WAIT_I;
            pcm_pkg::S_WAIT_I: begin
                if (i_stat.mul_done) n_state = pcm_pkg::S_MUL_D;
            end
            pcm_pkg::S_MUL_D:  n_state = pcm_pkg::S_WAIT_D;
            pcm_pkg::S_WAIT_D: begin
                if (i_stat.mul_done) n_state = pcm_pkg::S_DONE;
            end
            pcm_pkg::S_DONE: begin
                if (i_stat.out_free) n_state = pcm_pkg::S_IDLE;
            end
            default: n_state = pcm_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_cmd.msel = pcm_pkg::MSEL_FILT;
        o_in_ready = 1'b0;
        case (r_state)
            pcm_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            pcm_pkg::S_FILT: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.msel   = pcm_pkg::MSEL_FILT;
            end
            pcm_pkg::S_FILT_WAIT: o_cmd.filt_store = i_stat.mul_done;
            pcm_pkg::S_ERR:       o_cmd.err_step = 1'b1;
            pcm_pkg::S_DIV:       o_cmd.div_go = 1'b1;
            pcm_pkg::S_SUM:       o_cmd.sum_step = 1'b1;
            pcm_pkg::S_MUL_P: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.msel   = pcm_pkg::MSEL_P;
            end
            pcm_pkg::S_MUL_I: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.msel   = pcm_pkg::MSEL_I;
            end
            pcm_pkg::S_MUL_D: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.msel   = pcm_pkg::MSEL_D;
            end
            pcm_pkg::S_WAIT_P,
            pcm_pkg::S_WAIT_I,
            pcm_pkg::S_WAIT_D:    o_cmd.acc_add = i_stat.mul_done;
            pcm_pkg::S_DONE:      o_cmd.out_load = i_stat.out_free;
            default: ;
        endcase
    end
endmodule

// ----- hw/rtl/pcm_dp.sv -----
// datapath: registers, state, operand selection, the shared multiplier and the divider
module pcm_dp #(
    parameter int VALUE_FRAC_BITS = pcm_pkg::VALUE_FRAC_BITS,
    parameter int GAIN_FRAC_BITS  = pcm_pkg::GAIN_FRAC_BITS,
    parameter int SUM_WIDTH       = pcm_pkg::SUM_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pcm_pkg::t_cmd                      i_cmd,
    output pcm_pkg::t_stat                     o_stat,
    input  logic                               i_cfg_we,
    input  logic [pcm_pkg::IDX_W-1:0]          i_cfg_index,
    input  logic [pcm_pkg::DATA_W-1:0]         i_cfg_data,
    input  logic signed [pcm_pkg::DATA_W-1:0]  i_target,
    input  logic signed [pcm_pkg::DATA_W-1:0]  i_measured,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic signed [pcm_pkg::DATA_W-1:0]  o_drive,
    output logic                               o_limited
);
    localparam int DW    = pcm_pkg::DATA_W;
    localparam int EW    = pcm_pkg::ERR_W;
    localparam int AW    = pcm_pkg::MUL_A_W;
    localparam int XW    = EW + 2;
    localparam int YW    = DW + 3;
    localparam int B_W   = SUM_WIDTH;
    localparam int PW    = AW + B_W;
    localparam int O_W   = PW + 2;
    localparam int NUM_W = DW + GAIN_FRAC_BITS;
    localparam int CW    = ((SUM_WIDTH > NUM_W) ? SUM_WIDTH : NUM_W) + 2;
    localparam int HALF  = 180 << VALUE_FRAC_BITS;
    localparam int FULL  = 360 << VALUE_FRAC_BITS;
    localparam int BAND  = 2 << VALUE_FRAC_BITS;
    localparam int DZ    = (1 << VALUE_FRAC_BITS) / 2;

    localparam logic signed [YW-1:0] Y_HALF = YW'(HALF);
    localparam logic signed [YW-1:0] Y_FULL = YW'(FULL);
    localparam logic signed [YW-1:0] Y_BAND = YW'(BAND);
    localparam logic signed [XW-1:0] X_DZ   = XW'(DZ);
    localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    // configuration
    logic [1:0]                   r_mode;
    logic signed [DW-1:0]         r_gp, r_gi, r_gd, r_lo, r_hi;
    logic [pcm_pkg::ALPHA_W-1:0]  r_alpha;

    // controller state and current request
    logic signed [DW-1:0]         r_lf, r_ld, r_t, r_m;
    logic signed [EW-1:0]         r_en, r_ep, r_ep2;
    logic signed [SUM_WIDTH-1:0]  r_sum;
    logic signed [O_W-1:0]        r_o;

    // result register
    logic                         r_ovalid;
    logic signed [DW-1:0]         r_drive;
    logic                         r_lim;

    logic                         mul_done, div_done;
    logic signed [AW-1:0]         mul_a;
    logic signed [B_W-1:0]        mul_b;
    logic signed [PW-1:0]         prod, prod_g, prod_f;
    logic [NUM_W-1:0]             div_num, quo;
    logic [DW-1:0]                abs_hi, abs_gi;

    logic [pcm_pkg::ALPHA_W-1:0]  alpha_c;
    logic signed [EW-1:0]         m_diff, pos_err;
    logic signed [XW-1:0]         en_x, ep_x, ep2_x, x_p, x_d;
    logic signed [YW-1:0]         yd;
    logic                         y_dead;
    logic signed [SUM_WIDTH:0]    s_add;
    logic signed [SUM_WIDTH-1:0]  s_sat;
    logic signed [CW-1:0]         s_w, s_lim, s_cl;
    logic signed [O_W-1:0]        o_hi, o_lo, o_cl;
    logic                         o_lim;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= pcm_pkg::MODE_POS;
            r_gp    <= '0;
            r_gi    <= '0;
            r_gd    <= '0;
            r_alpha <= '0;
            r_lo    <= '0;
            r_hi    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pcm_pkg::REG_MODE:   r_mode  <= i_cfg_data[1:0];
                pcm_pkg::REG_GAIN_P: r_gp    <= i_cfg_data;
                pcm_pkg::REG_GAIN_I: r_gi    <= i_cfg_data;
                pcm_pkg::REG_GAIN_D: r_gd    <= i_cfg_data;
                pcm_pkg::REG_ALPHA:  r_alpha <= i_cfg_data[pcm_pkg::ALPHA_W-1:0];
                pcm_pkg::REG_OUT_LO: r_lo    <= i_cfg_data;
                pcm_pkg::REG_OUT_HI: r_hi    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // error history helpers
    assign en_x  = {{2{r_en[EW-1]}}, r_en};
    assign ep_x  = {{2{r_ep[EW-1]}}, r_ep};
    assign ep2_x = {{2{r_ep2[EW-1]}}, r_ep2};
    assign alpha_c = (r_alpha > pcm_pkg::ALPHA_ONE) ? pcm_pkg::ALPHA_ONE : r_alpha;
    assign m_diff  = {r_m[DW-1], r_m} - {r_lf[DW-1], r_lf};
    assign pos_err = {r_t[DW-1], r_t} - {r_lf[DW-1], r_lf};

    // proportional and derivative operands per mode
    always_comb begin
        x_p = en_x;
        x_d = en_x - ep_x;
        if (r_mode == pcm_pkg::MODE_INC) begin
            x_p = en_x - ep_x;
            x_d = en_x - (ep_x <<< 1) + ep2_x;
        end else if (r_mode == pcm_pkg::MODE_YAW) begin
            if ((en_x - ep_x) < X_DZ && (en_x - ep_x) > -X_DZ) x_d = '0;
        end
    end

    // multiplier operand select
    always_comb begin
        case (i_cmd.msel)
            pcm_pkg::MSEL_FILT: begin
                mul_a = {{(AW-pcm_pkg::ALPHA_W){1'b0}}, alpha_c};
                mul_b = {{(B_W-EW){m_diff[EW-1]}}, m_diff};
            end
            pcm_pkg::MSEL_P: begin
                mul_a = {r_gp[DW-1], r_gp};
                mul_b = {{(B_W-XW){x_p[XW-1]}}, x_p};
            end
            pcm_pkg::MSEL_I: begin
                mul_a = {r_gi[DW-1], r_gi};
                if (r_mode == pcm_pkg::MODE_INC) mul_b = {{(B_W-XW){en_x[XW-1]}}, en_x};
                else                             mul_b = r_sum;
            end
            pcm_pkg::MSEL_D: begin
                mul_a = {r_gd[DW-1], r_gd};
                mul_b = {{(B_W-XW){x_d[XW-1]}}, x_d};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    pcm_mul #(.B_W(B_W)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_go),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    assign prod_g = prod >>> GAIN_FRAC_BITS;
    assign prod_f = prod >>> pcm_pkg::ALPHA_FRAC;

    // integral limit |out_high_limit| scaled by the gain fraction over |gain_i|
    assign abs_hi  = r_hi[DW-1] ? DW'(-r_hi) : DW'(r_hi);
    assign abs_gi  = r_gi[DW-1] ? DW'(-r_gi) : DW'(r_gi);
    assign div_num = {abs_hi, {GAIN_FRAC_BITS{1'b0}}};

    pcm_div #(.N_W(NUM_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_go),
        .i_num   (div_num),
        .i_den   (abs_gi),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    // yaw error wrap and dead band
    always_comb begin
        yd = {{3{r_t[DW-1]}}, r_t} - {{3{r_m[DW-1]}}, r_m};
        if (yd > Y_HALF)  yd = yd - Y_FULL;
        if (yd < -Y_HALF) yd = yd + Y_FULL;
        y_dead = (yd < Y_BAND) && (yd > -Y_BAND);
    end

    // saturating integral add, then clamp to the integral limit while the integral gain is nonzero
    always_comb begin
        s_add = {r_sum[SUM_WIDTH-1], r_sum} + {{(SUM_WIDTH+1-EW){r_en[EW-1]}}, r_en};
        if (s_add[SUM_WIDTH] != s_add[SUM_WIDTH-1]) begin
            s_sat = s_add[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
        end else begin
            s_sat = s_add[SUM_WIDTH-1:0];
        end
        s_w   = {{(CW-SUM_WIDTH){s_sat[SUM_WIDTH-1]}}, s_sat};
        s_lim = {{(CW-NUM_W){1'b0}}, quo};
        s_cl  = s_w;
        if (r_gi != '0) begin
            if (s_cl > s_lim)  s_cl = s_lim;
            if (s_cl < -s_lim) s_cl = -s_lim;
        end
    end

    // output clamp, high first then low
    always_comb begin
        o_hi  = {{(O_W-DW){r_hi[DW-1]}}, r_hi};
        o_lo  = {{(O_W-DW){r_lo[DW-1]}}, r_lo};
        o_cl  = r_o;
        o_lim = 1'b0;
        if (o_cl > o_hi) begin
            o_cl  = o_hi;
            o_lim = 1'b1;
        end
        if (o_cl < o_lo) begin
            o_cl  = o_lo;
            o_lim = 1'b1;
        end
    end

    // controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lf  <= '0;
            r_en  <= '0;
            r_ep  <= '0;
            r_ep2 <= '0;
            r_sum <= '0;
            r_ld  <= '0;
        end else begin
            if (i_cmd.filt_store) begin
                r_lf <= r_lf + prod_f[DW-1:0];
            end
            if (i_cmd.err_step) begin
                r_ep <= r_en;
                if (r_mode == pcm_pkg::MODE_YAW) begin
                    r_en <= y_dead ? '0 : yd[EW-1:0];
                    if (y_dead) r_sum <= '0;
                end else begin
                    r_en <= pos_err;
                    if (r_mode == pcm_pkg::MODE_INC) r_ep2 <= r_ep;
                end
            end
            if (i_cmd.sum_step) begin
                r_sum <= s_cl[SUM_WIDTH-1:0];
            end
            if (i_cmd.out_load) begin
                r_ld <= o_cl[DW-1:0];
            end
        end
    end

    // request capture and term accumulation
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_t <= i_target;
            r_m <= i_measured;
        end
        if (i_cmd.err_step) begin
            r_o <= (r_mode == pcm_pkg::MODE_INC) ? {{(O_W-DW){r_ld[DW-1]}}, r_ld} : '0;
        end else if (i_cmd.acc_add) begin
            r_o <= r_o + {{2{prod_g[PW-1]}}, prod_g};
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_drive <= o_cl[DW-1:0];
            r_lim   <= o_lim;
        end
    end

    assign o_stat.mode     = r_mode;
    assign o_stat.gi_zero  = (r_gi == '0);
    assign o_stat.mul_done = mul_done;
    assign o_stat.div_done = div_done;
    assign o_stat.out_free = !r_ovalid || i_out_ready;

    assign o_out_valid = r_ovalid;
    assign o_drive     = r_drive;
    assign o_limited   = r_lim;
endmodule

// ----- hw/rtl/pid_controller_three_mode.sv -----
// Three-mode PID controller (positional, incremental, yaw) giving one clamped drive value per
// request. One request is worked at a time; a finished drive waits in the output register while
// the next request is taken and worked. Each gain product goes through one bit-serial multiplier
// with 25 multiplier bits, and the integral limit comes from a restoring divider. A request needs
// four products and the divide in positional mode, four products and no divide in incremental
// mode, and three products and the divide in yaw mode; the divide is skipped while the integral
// gain is zero. Configuration writes are taken every cycle.
module pid_controller_three_mode #(
    parameter int VALUE_FRAC_BITS = pcm_pkg::VALUE_FRAC_BITS,
    parameter int GAIN_FRAC_BITS  = pcm_pkg::GAIN_FRAC_BITS,
    parameter int SUM_WIDTH       = pcm_pkg::SUM_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pcm_in_if.sink     i_in,
    pcm_cfg_if.sink    i_cfg,
    pcm_out_if.source  o_out
);
    pcm_pkg::t_cmd  cmd;
    pcm_pkg::t_stat stat;

    assign i_cfg.ready = 1'b1;

    pcm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pcm_dp #(
        .VALUE_FRAC_BITS (VALUE_FRAC_BITS),
        .GAIN_FRAC_BITS  (GAIN_FRAC_BITS),
        .SUM_WIDTH       (SUM_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_target    (i_in.target),
        .i_measured  (i_in.measured),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_drive     (o_out.drive),
        .o_limited   (o_out.output_limited)
    );
endmodule

// ----- hw/rtl/pcm_chk.sv -----
// port-level checks of the three-mode pid controller, bound to the top level
`include "pid_controller_three_mode_macros.svh"

module pcm_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic signed [pcm_pkg::DATA_W-1:0] i_drive
);
    logic [1:0] r_pend;
    logic [1:0] n_pend;

    // requests taken but not yet delivered
    always_comb begin
        n_pend = r_pend;
        if (i_in_valid && i_in_ready)   n_pend = n_pend + 2'd1;
        if (i_out_valid && i_out_ready) n_pend = n_pend - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    `PCM_ASSERT_CLK(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_drive), "drive changed while stalled")
    `PCM_ASSERT_NEVER(a_no_phantom, i_clk, i_rst_n, i_out_valid && r_pend == 2'd0, "result without request")
    `PCM_ASSERT_NEVER(a_depth, i_clk, i_rst_n, i_in_ready && r_pend == 2'd2, "third request accepted")
endmodule

bind pid_controller_three_mode pcm_chk u_pcm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_drive     (o_out.drive)
);
